// File: hw/rtl/cis_tuple_walker_defines.svh
// assertion macros used by the tuple walker checker
`ifndef CIS_TUPLE_WALKER_DEFINES_SVH
`define CIS_TUPLE_WALKER_DEFINES_SVH

// property checked outside reset
`define CTW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ctw_pkg.sv
// package: types, codes and constants of the cis tuple walker
`timescale 1ns / 1ps

package ctw_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned OffsetW    = 10;
  localparam int unsigned PosW       = 2;
  localparam int unsigned ScanLimit  = 256;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned RegIdxW    = 2;

  localparam logic [ByteW-1:0] EndCodeRst      = 8'hFF;
  localparam logic [ByteW-1:0] ManufCodeRst    = 8'd32;
  localparam logic [ByteW-1:0] FuncCodeRst     = 8'd33;
  localparam logic [ByteW-1:0] FixedDiskRst    = 8'd4;

  typedef enum logic [RegIdxW-1:0] {
    REG_END_CODE   = 2'd0,
    REG_MANUF_CODE = 2'd1,
    REG_FUNC_CODE  = 2'd2,
    REG_FIXED_DISK = 2'd3
  } ctw_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TYPE = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } ctw_phase_e;

  typedef enum logic [1:0] {
    STOP_END_TUPLE = 2'd0,
    STOP_ZERO_LEN  = 2'd1,
    STOP_LIMIT     = 2'd2
  } ctw_stop_e;

  typedef struct packed {
    logic [ByteW-1:0] end_code;
    logic [ByteW-1:0] manufacturer_code;
    logic [ByteW-1:0] function_code;
    logic [ByteW-1:0] fixed_disk_code;
  } ctw_cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] cis_byte;
    logic             start_scan;
    logic             socket_index;
  } ctw_item_t;

  typedef struct packed {
    ctw_stop_e        stop_reason;
    logic [ByteW-1:0] manufacturer_low;
    logic [ByteW-1:0] manufacturer_high;
    logic [ByteW-1:0] function_id;
    logic             fixed_disk;
    logic             scanned_socket;
  } ctw_result_t;

endpackage

// File: hw/rtl/ctw_in_if.sv
// byte input channel: valid/ready with one attribute memory byte
`timescale 1ns / 1ps

interface ctw_in_if;
  import ctw_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] cis_byte;
  logic             start_scan;
  logic             socket_index;

  modport source (output valid, cis_byte, start_scan, socket_index, input ready);
  modport sink   (input valid, cis_byte, start_scan, socket_index, output ready);
endinterface

// File: hw/rtl/ctw_out_if.sv
// result channel: valid/ready with the scan summary
`timescale 1ns / 1ps

interface ctw_out_if;
  import ctw_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       stop_reason;
  logic [ByteW-1:0] manufacturer_low;
  logic [ByteW-1:0] manufacturer_high;
  logic [ByteW-1:0] function_id;
  logic             fixed_disk;
  logic             scanned_socket;

  modport source (output valid, stop_reason, manufacturer_low, manufacturer_high,
                  function_id, fixed_disk, scanned_socket, input ready);
  modport sink   (input valid, stop_reason, manufacturer_low, manufacturer_high,
                  function_id, fixed_disk, scanned_socket, output ready);
endinterface

// File: hw/rtl/ctw_cfg_regs.sv
// apb configuration registers of the tuple walker
`timescale 1ns / 1ps

module ctw_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ctw_pkg::ApbAddrW-1:0]    paddr,
  input  logic [ctw_pkg::ApbDataW-1:0]    pwdata,
  output logic [ctw_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready,
  output ctw_pkg::ctw_cfg_t               cfg_o
);
  import ctw_pkg::*;

  ctw_cfg_t         cfg_q, cfg_d;
  ctw_reg_e         reg_idx;
  logic             wr_en;
  logic [ByteW-1:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = ctw_reg_e'(paddr[ApbAddrW-1:ApbAddrW-RegIdxW]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_END_CODE:   cfg_d.end_code          = pwdata[ByteW-1:0];
        REG_MANUF_CODE: cfg_d.manufacturer_code = pwdata[ByteW-1:0];
        REG_FUNC_CODE:  cfg_d.function_code     = pwdata[ByteW-1:0];
        REG_FIXED_DISK: cfg_d.fixed_disk_code   = pwdata[ByteW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_END_CODE:   rd_val = cfg_q.end_code;
      REG_MANUF_CODE: rd_val = cfg_q.manufacturer_code;
      REG_FUNC_CODE:  rd_val = cfg_q.function_code;
      REG_FIXED_DISK: rd_val = cfg_q.fixed_disk_code;
      default:        rd_val = '0;
    endcase
  end

  assign prdata = ApbDataW'(rd_val);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_code          <= EndCodeRst;
      cfg_q.manufacturer_code <= ManufCodeRst;
      cfg_q.function_code     <= FuncCodeRst;
      cfg_q.fixed_disk_code   <= FixedDiskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hw/rtl/ctw_walker.sv
// tuple chain state and the per-byte step logic
`timescale 1ns / 1ps

module ctw_walker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctw_pkg::ctw_cfg_t    cfg_i,
  input  logic                 step_i,
  input  ctw_pkg::ctw_item_t   item_i,
  output logic                 emit_o,
  output ctw_pkg::ctw_result_t result_o
);
  import ctw_pkg::*;

  ctw_phase_e         phase_q, phase_d, cur_phase;
  logic [OffsetW-1:0] offset_q, offset_d, offset_base;
  logic [ByteW-1:0]   kind_q, kind_d;
  logic [ByteW-1:0]   remain_q, remain_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [2*ByteW-1:0] manuf_q, manuf_d;
  logic [ByteW-1:0]   func_q, func_d;
  logic               sock_q, sock_d;
  logic               emit;
  ctw_stop_e          reason;
  logic               is_manuf, is_func;

  assign is_manuf = (kind_q == cfg_i.manufacturer_code);
  assign is_func  = (kind_q == cfg_i.function_code);

  always_comb begin
    // a start byte restarts the walk as the first type byte
    cur_phase   = item_i.start_scan ? PH_TYPE : phase_q;
    offset_base = item_i.start_scan ? '0 : offset_q;
    manuf_d     = item_i.start_scan ? '0 : manuf_q;
    func_d      = item_i.start_scan ? '0 : func_q;
    sock_d      = item_i.start_scan ? item_i.socket_index : sock_q;
    phase_d     = cur_phase;
    offset_d    = offset_base;
    kind_d      = kind_q;
    remain_d    = remain_q;
    pos_d       = pos_q;
    emit        = 1'b0;
    reason      = STOP_END_TUPLE;

    unique case (cur_phase)
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      PH_TYPE: begin
        kind_d   = item_i.cis_byte;
        phase_d  = PH_LEN;
        offset_d = offset_base + OffsetW'(1);
      end
      PH_LEN: begin
        offset_d = offset_base + OffsetW'(1);
        if (kind_q == cfg_i.end_code) begin
          emit    = 1'b1;
          reason  = STOP_END_TUPLE;
          phase_d = PH_IDLE;
        end else if (item_i.cis_byte == '0) begin
          emit    = 1'b1;
          reason  = STOP_ZERO_LEN;
          phase_d = PH_IDLE;
        end else begin
          remain_d = item_i.cis_byte;
          pos_d    = '0;
          phase_d  = PH_BODY;
          if (is_manuf) begin
            manuf_d = '0;
          end
        end
      end
      PH_BODY: begin
        if (is_manuf) begin
          if (pos_q == PosW'(0)) begin
            manuf_d[ByteW-1:0] = item_i.cis_byte;
          end else if (pos_q == PosW'(1)) begin
            manuf_d[2*ByteW-1:ByteW] = item_i.cis_byte;
          end
        end else if (is_func && pos_q == PosW'(0)) begin
          func_d = item_i.cis_byte;
        end
        // position saturates once both capture slots are past
        if (pos_q < PosW'(2)) begin
          pos_d = pos_q + PosW'(1);
        end
        remain_d = remain_q - ByteW'(1);
        offset_d = offset_base + OffsetW'(1);
        if (remain_d == '0) begin
          if (offset_d >= OffsetW'(ScanLimit)) begin
            emit    = 1'b1;
            reason  = STOP_LIMIT;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_TYPE;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  assign emit_o                     = step_i && emit;
  assign result_o.stop_reason       = reason;
  assign result_o.manufacturer_low  = manuf_d[ByteW-1:0];
  assign result_o.manufacturer_high = manuf_d[2*ByteW-1:ByteW];
  assign result_o.function_id       = func_d;
  assign result_o.fixed_disk        = (func_d == cfg_i.fixed_disk_code);
  assign result_o.scanned_socket    = sock_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      offset_q <= '0;
      kind_q   <= '0;
      remain_q <= '0;
      pos_q    <= '0;
      manuf_q  <= '0;
      func_q   <= '0;
      sock_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      kind_q   <= kind_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
      manuf_q  <= manuf_d;
      func_q   <= func_d;
      sock_q   <= sock_d;
    end
  end

endmodule

// File: hw/rtl/cis_tuple_walker.sv
// Card information structure tuple walker, top level.
// in_ch carries one attribute memory byte per transfer, in offset order, with
// start_scan marking the first type byte of a scan and socket_index the socket.
// out_ch carries one summary per finished walk: stop reason, manufacturer bytes,
// function id, fixed-disk flag and the scanned socket.
// The apb port holds the end, manufacturer, function and fixed-disk codes,
// written between scans.
// Each accepted byte waits in the input register until the step logic updates the
// walk state and loads the result register, so out_ch.valid rises from the result
// register once the byte that ends the walk has been stepped.
// Throughput is one byte per cycle while no summary is held by a stalled receiver.
// A finished summary waits in the result register; while the receiver stalls
// with a summary pending, the byte in the input register holds and in_ch.ready
// stays low, whether or not that byte would end a walk.
// Reset empties both registers, returns the walk to idle with captures cleared
// and loads the default codes.
`timescale 1ns / 1ps

module cis_tuple_walker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ctw_in_if.sink                          in_ch,
  ctw_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ctw_pkg::ApbAddrW-1:0]    paddr,
  input  logic [ctw_pkg::ApbDataW-1:0]    pwdata,
  output logic [ctw_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import ctw_pkg::*;

  ctw_cfg_t    cfg;
  logic        in_valid_q;
  ctw_item_t   in_item_q;
  logic        step;
  logic        emit;
  ctw_result_t result;
  logic        out_valid_q;
  ctw_result_t out_res_q;

  ctw_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ctw_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (in_item_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // the step may run whenever the result register is free or draining now
  assign step        = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_q.cis_byte     <= in_ch.cis_byte;
      in_item_q.start_scan   <= in_ch.start_scan;
      in_item_q.socket_index <= in_ch.socket_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_res_q <= result;
    end
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.stop_reason       = out_res_q.stop_reason;
  assign out_ch.manufacturer_low  = out_res_q.manufacturer_low;
  assign out_ch.manufacturer_high = out_res_q.manufacturer_high;
  assign out_ch.function_id       = out_res_q.function_id;
  assign out_ch.fixed_disk        = out_res_q.fixed_disk;
  assign out_ch.scanned_socket    = out_res_q.scanned_socket;

endmodule

// File: hw/rtl/ctw_checker.sv
// port-level assertions for the tuple walker and their bind
`timescale 1ns / 1ps
`include "cis_tuple_walker_defines.svh"

module ctw_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      start_scan_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input ctw_pkg::ctw_result_t      out_res_i
);
  import ctw_pkg::*;

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // a pending summary stays until its transfer
  `CTW_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_stall |=> out_valid_i, "summary dropped while stalled")

  // a stalled summary keeps its contents
  `CTW_ASSERT(a_out_res_stable, clk_i, rst_ni, out_stall |=> $stable(out_res_i), "summary changed while stalled")

  // a fresh summary comes from a byte taken earlier through the input and result registers
  `CTW_ASSERT(a_out_latency, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_xfer, 2), "summary without a source byte")

  // a start byte is a type byte and never ends a walk
  `CTW_ASSERT(a_start_no_emit, clk_i, rst_ni, (in_xfer && start_scan_i) |-> ##2 !$rose(out_valid_i), "start byte ended a walk")

  // reset leaves no summary pending
  `CTW_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i, "summary pending in reset")

endmodule

bind cis_tuple_walker ctw_checker u_ctw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .start_scan_i (in_ch.start_scan),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_res_i    ({out_ch.stop_reason, out_ch.manufacturer_low, out_ch.manufacturer_high,
                  out_ch.function_id, out_ch.fixed_disk, out_ch.scanned_socket})
);
